// ----- rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int ECNT_W   = 7;
  // Compare width: wide enough for count + 1 and for the position field
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  // Read-back OR tree: leaves grouped in eights, one register per group
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_READ_AT   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic              rd;
    logic [IDX_W-1:0]  rd_idx;
  } cell_ctl_t;

endpackage

// ----- rtl/ple_in_if.sv -----
// ----------------------------------------------------------------------------
// ple_in_if
// Command channel: valid/ready handshake with command, value and position.
// ----------------------------------------------------------------------------
interface ple_in_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               command;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

// ----- rtl/ple_out_if.sv -----
// ----------------------------------------------------------------------------
// ple_out_if
// Result channel: valid/ready handshake with status, count and read data.
// ----------------------------------------------------------------------------
interface ple_out_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [ECNT_W-1:0]        element_count;
  logic signed [DATA_W-1:0] read_data;

  modport source (output valid, status, element_count, read_data, input ready);
  modport sink   (input valid, status, element_count, read_data, output ready);
endinterface

// ----- rtl/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a value, shifts up on insert, down on delete.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic [DATA_W-1:0] prev_val,
  input  logic [DATA_W-1:0] next_val,
  output logic [DATA_W-1:0] val,
  output logic [DATA_W-1:0] sel_val
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && (cell_idx == ctl.idx)) begin
      val_nxt = ctl.value;
    end else if (ctl.ins && (cell_idx > ctl.idx)) begin
      val_nxt = prev_val;
    end else if (ctl.del && (cell_idx >= ctl.idx)) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val     = val_r;
  assign sel_val = (ctl.rd && (cell_idx == ctl.rd_idx)) ? val_r : '0;

endmodule

// ----- rtl/ple_chain.sv -----
// ----------------------------------------------------------------------------
// ple_chain
// Row of list cells plus a registered OR tree for positional reads.
// ----------------------------------------------------------------------------
module ple_chain import ple_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] vals    [CAPACITY];
  logic [DATA_W-1:0] sels    [CAPACITY];
  logic [DATA_W-1:0] grp_r   [NGRP];
  logic [DATA_W-1:0] grp_nxt [NGRP];

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] prev_v;
      logic [DATA_W-1:0] next_v;
      if (i == 0) begin : g_first
        assign prev_v = '0;
      end else begin : g_mid_p
        assign prev_v = vals[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign next_v = '0;
      end else begin : g_mid_n
        assign next_v = vals[i+1];
      end
      ple_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .cell_idx (IDX_W'(i)),
        .prev_val (prev_v),
        .next_val (next_v),
        .val      (vals[i]),
        .sel_val  (sels[i])
      );
    end
  endgenerate

  // First level: OR of each group of eight, registered
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | sels[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  always_comb begin
    rd_data = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_data = rd_data | grp_r[g];
    end
  end

endmodule

// ----- rtl/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with positional commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : command transactions (command, value, 1-based position).
//   out_ch : one result transaction per command (status, element count
//            after the command, read data for a successful read, else 0).
//   Each list slot is a cell in a chain; an insert shifts every cell past
//   the target up by one, all cells at once; a delete shifts them down.
//   Result path: on the accept edge the cells update and the read OR tree's
//   group stage registers; the final OR then loads the result register,
//   and out_ch.valid rises with it. One command is in flight at a time:
//   in_ch.ready returns high only once the result has been taken.
//   Reset (rst_n low, synchronous): the list is emptied, no result pending,
//   in_ch.ready high once reset is released. Slot contents are not cleared.
//   Stall: a result holds on out_ch until taken; in_ch.ready stays low
//   meanwhile.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GATHER = 3'b010,
    S_OUT    = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  status_t           status_r, status_nxt;
  logic [1:0]        out_status_r;
  logic [ECNT_W-1:0] out_cnt_r;
  logic [DATA_W-1:0] out_data_r;
  cell_ctl_t         ctl;
  logic [DATA_W-1:0] chain_rd;

  logic             accept;
  logic             full, empty;
  logic [CMP_W-1:0] pos_e, occ_e, pos_m1, occ_m1;
  logic             ins_pos_ok, pos_ok;
  logic [CMP_W-1:0] cnt_e;

  assign accept = in_ch.valid && in_ch.ready;
  assign full   = (occ_r >= CNT_W'(CAPACITY));
  assign empty  = (occ_r == '0);
  assign pos_e  = CMP_W'(in_ch.position);
  assign occ_e  = CMP_W'(occ_r);
  assign pos_m1 = pos_e - CMP_W'(1);
  assign occ_m1 = occ_e - CMP_W'(1);
  // 1-based range checks; insert accepts one past the last element
  assign ins_pos_ok = (pos_e != '0) && (pos_e <= occ_e + CMP_W'(1));
  assign pos_ok     = (pos_e != '0) && (pos_e <= occ_e);

  // Command decode: status, count update and the broadcast to the cells
  always_comb begin
    status_nxt = ST_OK;
    occ_nxt    = occ_r;
    ctl        = '0;
    ctl.value  = in_ch.value;
    if (accept) begin
      unique case (cmd_t'(in_ch.command))
        CMD_INS_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            ctl.idx = '0;
          end
        end
        CMD_INS_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            ctl.idx = occ_e[IDX_W-1:0];
          end
        end
        CMD_INS_AT: begin
          if (!ins_pos_ok) begin
            status_nxt = ST_BADPOS;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            ctl.idx = pos_m1[IDX_W-1:0];
          end
        end
        CMD_DEL_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.del = 1'b1;
            ctl.idx = '0;
          end
        end
        CMD_DEL_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.del = 1'b1;
            ctl.idx = occ_m1[IDX_W-1:0];
          end
        end
        CMD_DEL_AT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else if (!pos_ok) begin
            status_nxt = ST_BADPOS;
          end else begin
            ctl.del = 1'b1;
            ctl.idx = pos_m1[IDX_W-1:0];
          end
        end
        CMD_READ_AT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else if (!pos_ok) begin
            status_nxt = ST_BADPOS;
          end else begin
            ctl.rd     = 1'b1;
            ctl.rd_idx = pos_m1[IDX_W-1:0];
          end
        end
        default: status_nxt = ST_BADPOS;  // unused command code
      endcase
      if (ctl.ins) begin
        occ_nxt = occ_r + CNT_W'(1);
      end else if (ctl.del) begin
        occ_nxt = occ_r - CNT_W'(1);
      end
    end
  end

  ple_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (chain_rd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_GATHER;
      S_GATHER: state_nxt = S_OUT;
      S_OUT:    if (out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Result registers (payload, no reset)
  assign cnt_e = CMP_W'(occ_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    if (state_r == S_GATHER) begin
      out_status_r <= status_r;
      out_cnt_r    <= cnt_e[ECNT_W-1:0];
      out_data_r   <= chain_rd;
    end
  end

  // No transaction is taken while reset is held
  assign in_ch.ready          = (state_r == S_IDLE) && rst_n;
  assign out_ch.valid         = (state_r == S_OUT);
  assign out_ch.status        = out_status_r;
  assign out_ch.element_count = out_cnt_r;
  assign out_ch.read_data     = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GATHER) && (status_r == ST_FULL) |-> occ_r == CNT_W'(CAPACITY))
    else $error("full status on a list with room");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_OK) |-> out_ch.read_data == '0)
    else $error("read data nonzero on a failed command");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status_nxt != ST_OK) |=> $stable(occ_r))
    else $error("count changed on a refused command");

endmodule
